// ===== rtl/gedd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the gray error-diffusion dither: sizes, register indexes,
// the pixel item that the front hands to the back, and the shared arithmetic.
// No dependencies.
package gedd_pkg;

   // Line buffer and position sizes.
   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Pixel and error widths.
   localparam int PIX_W = 8;
   localparam int ERR_W = 9;

   // Luma weights in 16-bit fixed point, plus the rounding constant.
   localparam logic [16:0] LUMA_R     = 17'd19595;
   localparam logic [16:0] LUMA_G     = 17'd38470;
   localparam logic [16:0] LUMA_B     = 17'd7471;
   localparam logic [23:0] LUMA_ROUND = 24'd32768;

   // One classified pixel as it travels through the queue.
   typedef struct packed {
      logic [PIX_W-1:0] gray;
      logic [COL_W-1:0] col;
      logic             has_upper;
      logic             has_left;
      logic             last;
   } gedd_item_type;

   // Gray value from RGB, rounded.
   function automatic logic [PIX_W-1:0] luma(input logic [PIX_W-1:0] r,
                                             input logic [PIX_W-1:0] g,
                                             input logic [PIX_W-1:0] b);
      logic [23:0] sum;
      sum = 24'(LUMA_R * 24'(r)) + 24'(LUMA_G * 24'(g)) + 24'(LUMA_B * 24'(b))
            + LUMA_ROUND;
      return sum[23:16];
   endfunction

   // Adds err*2/8 (or err*3/8 when three is set), rounded half up, clamped.
   function automatic logic [PIX_W-1:0] add_share(input logic [PIX_W-1:0] value,
                                                  input logic three,
                                                  input logic signed [ERR_W-1:0] err);
      logic signed [11:0] e_x;
      logic signed [11:0] scaled;
      logic signed [11:0] sum;
      e_x    = $signed({{(12-ERR_W){err[ERR_W-1]}}, err});
      scaled = (e_x <<< 1) + (three ? e_x : 12'sd0) + 12'sd4;
      sum    = $signed({4'b0, value}) + (scaled >>> 3);
      if (sum < 12'sd0) begin
         return '0;
      end else if (sum > 12'sd255) begin
         return '1;
      end else begin
         return sum[PIX_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/gedd_front.sv =====
`timescale 1ns / 1ps
// Front part: holds the image size registers, tracks the raster position,
// turns each RGB beat into a gray pixel item. Depends on gedd_pkg.
module gedd_front import gedd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIX_W-1:0]       req_red,
   input  logic [PIX_W-1:0]       req_green,
   input  logic [PIX_W-1:0]       req_blue,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   push_valid,
   input  logic                   push_ready,
   output gedd_item_type          push_item
);

   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [WIDTH_REG_W-1:0]  width_eff;
   logic [HEIGHT_REG_W-1:0] height_eff;
   logic                    last_col, last_row, accept;

   // Zero counts as one, oversize saturates.
   always_comb begin
      if (width_ff == '0) begin
         width_eff = WIDTH_REG_W'(1);
      end else if (width_ff > WIDTH_REG_W'(MAX_WIDTH)) begin
         width_eff = WIDTH_REG_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ff;
      end
      if (height_ff == '0) begin
         height_eff = HEIGHT_REG_W'(1);
      end else if (height_ff > HEIGHT_REG_W'(MAX_HEIGHT)) begin
         height_eff = HEIGHT_REG_W'(MAX_HEIGHT);
      end else begin
         height_eff = height_ff;
      end
   end

   assign last_col = (WIDTH_REG_W'(col_ff) + WIDTH_REG_W'(1)) == width_eff;
   assign last_row = (HEIGHT_REG_W'(row_ff) + HEIGHT_REG_W'(1)) == height_eff;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   // Classify the pixel by its position.
   always_comb begin
      push_item.gray      = luma(req_red, req_green, req_blue);
      push_item.col       = col_ff;
      push_item.has_upper = (row_ff != '0);
      push_item.has_left  = (col_ff != '0);
      push_item.last      = last_col && last_row;
   end

   // Register writes restart the frame; accepted beats step the position.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_valid) begin
         if (csr_index == CSR_IMAGE_WIDTH) begin
            width_in = csr_data[WIDTH_REG_W-1:0];
         end else if (csr_index == CSR_IMAGE_HEIGHT) begin
            height_in = csr_data[HEIGHT_REG_W-1:0];
         end
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_REG_W'(1024);
         height_ff <= HEIGHT_REG_W'(1024);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

// ===== rtl/gedd_queue.sv =====
`timescale 1ns / 1ps
// Short first-in first-out queue of pixel items between front and back.
// Depends on gedd_pkg.
module gedd_queue import gedd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  gedd_item_type push_item,
   output logic          pop_valid,
   input  logic          pop_ready,
   output gedd_item_type pop_item
);

   gedd_item_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots carry no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/gedd_back.sv =====
`timescale 1ns / 1ps
// Back part: reads the previous row's error from the line buffer, diffuses
// the neighbor errors, thresholds, and holds the result beat. Depends on gedd_pkg.
module gedd_back import gedd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  gedd_item_type pop_item,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_white,
   output logic          rsp_frame_end
);

   logic signed [ERR_W-1:0] line_mem [MAX_WIDTH];

   gedd_item_type           stage_ff;
   logic                    stage_valid_ff, stage_valid_in;
   logic signed [ERR_W-1:0] upper_ff;
   logic signed [ERR_W-1:0] left_ff;
   logic signed [ERR_W-1:0] upper_left_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    white_ff, frame_end_ff;

   logic                    out_free, advance, load;
   logic [PIX_W-1:0]        v1, v2, v3;
   logic                    white_new;
   logic signed [ERR_W-1:0] err_new;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = stage_valid_ff && out_free;
   assign pop_ready = !stage_valid_ff || out_free;
   assign load      = pop_valid && pop_ready;

   // Diffusion: upper-left, then upper, then left, each rounded and clamped.
   always_comb begin
      v1 = (stage_ff.has_upper && stage_ff.has_left)
           ? add_share(stage_ff.gray, 1'b0, upper_left_ff) : stage_ff.gray;
      v2 = stage_ff.has_upper ? add_share(v1, 1'b1, upper_ff) : v1;
      v3 = stage_ff.has_left ? add_share(v2, 1'b1, left_ff) : v2;
      white_new = v3[PIX_W-1];
      err_new   = white_new ? $signed({1'b0, v3}) - $signed(ERR_W'(255))
                            : $signed({1'b0, v3});
   end

   // Stage and result valid flags.
   always_comb begin
      stage_valid_in = load ? 1'b1 : (advance ? 1'b0 : stage_valid_ff);
      rsp_valid_in   = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         left_ff        <= '0;
         upper_left_ff  <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (advance) begin
            left_ff       <= err_new;
            upper_left_ff <= upper_ff;
         end
      end
   end

   // Line buffer write: each finished pixel leaves its error for the next row.
   always_ff @(posedge clock) begin
      if (advance) begin
         line_mem[stage_ff.col] <= err_new;
      end
   end

   // Line buffer read as the item enters the stage, bypassing a same-column write.
   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= pop_item;
         if (advance && (stage_ff.col == pop_item.col)) begin
            upper_ff <= err_new;
         end else begin
            upper_ff <= line_mem[pop_item.col];
         end
      end
   end

   // Result beat register.
   always_ff @(posedge clock) begin
      if (advance) begin
         white_ff     <= white_new;
         frame_end_ff <= stage_ff.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_white     = white_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

// ===== rtl/gray_error_diffusion_dither.sv =====
`timescale 1ns / 1ps
// Top level of the gray error-diffusion dither: front, queue and back.
// Depends on gedd_pkg, gedd_front, gedd_queue and gedd_back.
//
// Usage: RGB pixels enter in raster order on the req_ channel, one beat per
// pixel. Each gives one rsp_ beat: rsp_white is the dithered pixel, and
// rsp_frame_end marks the last pixel of a frame. The csr_ channel writes
// image_width (index 0) and image_height (index 1); csr_ready is always high,
// and a write restarts the frame at the first pixel. Write only while idle.
// Path: the queue slot, then the back stage, then the result beat register.
// Throughput: one pixel per cycle while the receiver takes every result beat,
// set by the left-error loop in the back part, registered in left_ff.
// The front accepts into a four-beat queue, so req_ready stays high while the
// receiver stalls until the queue fills; the result beat holds steady until
// taken. Reset empties the queue and result register, sets both image sizes
// to 1024 and restarts the frame. The line buffer holds no reset: an entry is
// only used after the row above has written it.
module gray_error_diffusion_dither import gedd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIX_W-1:0]       req_red,
   input  logic [PIX_W-1:0]       req_green,
   input  logic [PIX_W-1:0]       req_blue,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_white,
   output logic                   rsp_frame_end,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic          push_valid, push_ready, pop_valid, pop_ready;
   gedd_item_type push_item, pop_item;

   assign csr_ready = 1'b1;

   gedd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   gedd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   gedd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_item      (pop_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_white     (rsp_white),
      .rsp_frame_end (rsp_frame_end)
   );

   // A beat pushed while nothing leaves the queue must be visible next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_ready && !(pop_valid && pop_ready)) |=> pop_valid)
      else $error("queue lost a pushed beat");

   // A full queue is never empty.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> pop_valid)
      else $error("queue full while empty");

   // No result beat directly after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result beat holds steady even while the back stage takes a new beat.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && pop_ready) |=> !rsp_valid || $stable(rsp_white))
      else $error("result beat changed while stalled");

endmodule

// ===== test/gray_error_diffusion_dither_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gray_error_diffusion_dither: drives RGB beats,
// predicts the dithered pixel and frame end, and checks every result beat.
// Depends on gedd_pkg and the gray_error_diffusion_dither RTL.
module gray_error_diffusion_dither_tb;
   import gedd_pkg::*;

   localparam int TOTAL_PIXELS = 1250;
   localparam int WATCHDOG_NS  = 2_000_000;

   // Pixel content styles for a run of random beats.
   localparam int STYLE_NOISE     = 0;
   localparam int STYLE_FLAT      = 1;
   localparam int STYLE_SATURATED = 2;
   localparam int STYLE_RAMP      = 3;

   // Directed pixels: component extremes at the reset size, then a 3x3 frame
   // of grays that runs through every edge position and into the next frame.
   localparam logic [23:0] DIRECTED_RGB [24] = '{
      24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h808080,
      24'h7F7F7F, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h010101, 24'hFEFEFE,
      24'h646464, 24'hC8C8C8, 24'h323232, 24'hFFFFFF, 24'h000000, 24'h7F7F7F,
      24'h808080, 24'h5A5A5A, 24'hB4B4B4, 24'h1E1E1E, 24'hDCDCDC, 24'h8C8C8C
   };

   typedef struct packed {
      logic white;
      logic frame_end;
   } dithered_pixel_type;

   // Tracks the dither state of the block and the pixels still owed by it.
   class dither_tracker_type;
      int unsigned             width_reg;
      int unsigned             height_reg;
      logic signed [ERR_W-1:0] line_err [MAX_WIDTH];
      logic signed [ERR_W-1:0] left_err;
      logic signed [ERR_W-1:0] upper_left_err;
      int unsigned             col;
      int unsigned             row;
      dithered_pixel_type      dithered_q [$];
      int unsigned             mismatches;
      int unsigned             checked;
      int unsigned             frames;
      int unsigned             whites;

      function new();
         width_reg  = 1024;
         height_reg = 1024;
         foreach (line_err[i]) line_err[i] = '0;
         mismatches = 0;
         checked    = 0;
         frames     = 0;
         whites     = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         left_err       = '0;
         upper_left_err = '0;
         col            = 0;
         row            = 0;
      endfunction

      // A register write lands at once and starts a new frame.
      function void write_register(input logic [CSR_INDEX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_IMAGE_WIDTH) begin
            width_reg = data[WIDTH_REG_W-1:0];
         end else begin
            height_reg = data[HEIGHT_REG_W-1:0];
         end
         restart_frame();
      endfunction

      // Adds k/8 of a neighbour error, rounded half up, clamped to a pixel.
      function int share_error(input int value, input int k, input int err);
         int v;
         v = value + ((k * err + 4) >>> 3);
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         return v;
      endfunction

      function void note_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                               input logic [PIX_W-1:0] b);
         int unsigned        w;
         int unsigned        h;
         int unsigned        x;
         int unsigned        y;
         int unsigned        gray;
         int                 value;
         int                 upper;
         int                 err;
         dithered_pixel_type px;
         w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
         h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
         x = (col >= w) ? 0 : col;
         y = (row >= h) ? 0 : row;
         gray  = (19595 * int'(r) + 38470 * int'(g) + 7471 * int'(b) + 32768) >> 16;
         value = gray;
         upper = line_err[x];
         // Neighbours outside the image contribute nothing.
         if (y > 0 && x > 0) value = share_error(value, 2, upper_left_err);
         if (y > 0) value = share_error(value, 3, upper);
         if (x > 0) value = share_error(value, 3, left_err);
         px.white = (value > 127);
         err      = px.white ? value - 255 : value;
         upper_left_err = ERR_W'(upper);
         line_err[x]    = ERR_W'(err);
         left_err       = ERR_W'(err);
         px.frame_end   = (x + 1 == w) && (y + 1 == h);
         if (x + 1 >= w) begin
            col = 0;
            row = (y + 1 >= h) ? 0 : y + 1;
         end else begin
            col = x + 1;
            row = y;
         end
         dithered_q.push_back(px);
      endfunction

      function void check_result(input logic white, input logic frame_end);
         dithered_pixel_type want;
         if (dithered_q.size() == 0) begin
            $error("result beat with no pixel pending: white %0b, frame_end %0b",
                   white, frame_end);
            mismatches++;
            return;
         end
         want = dithered_q.pop_front();
         checked++;
         if (want.white !== white) begin
            $error("white: expected %0b, actual %0b", want.white, white);
            mismatches++;
         end
         if (want.frame_end !== frame_end) begin
            $error("frame_end: expected %0b, actual %0b", want.frame_end, frame_end);
            mismatches++;
         end
         if (frame_end === 1'b1) frames++;
         if (white === 1'b1) whites++;
      endfunction
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [PIX_W-1:0]       req_red   = '0;
   logic [PIX_W-1:0]       req_green = '0;
   logic [PIX_W-1:0]       req_blue  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_white;
   logic                   rsp_frame_end;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   dither_tracker_type sb = new();
   int                 send_idle_pct = 15;
   int                 stall_pct     = 69;
   int                 settings      = 1;
   int                 sent          = 0;

   gray_error_diffusion_dither i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_white     (rsp_white),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The receiver stalls at random, at a rate set by the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watch every channel: register writes and pixel beats feed the tracker,
   // result beats are checked against it.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_register(csr_index, csr_data);
         if (req_valid && req_ready) sb.note_pixel(req_red, req_green, req_blue);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_white, rsp_frame_end);
      end
   end

   initial begin
      #WATCHDOG_NS;
      $display("FAIL");
      $finish;
   end

   // Offers one pixel beat, after a random gap, and holds it until taken.
   task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b);
      // Idle rates follow how far the run has come.
      if (sent < TOTAL_PIXELS / 3) begin
         send_idle_pct = 15;
         stall_pct     = 69;
      end else if (sent < 2 * TOTAL_PIXELS / 3) begin
         send_idle_pct = 69;
         stall_pct     = 15;
      end else begin
         send_idle_pct = 0;
         stall_pct     = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   // Stops sending and waits until every owed result beat has come back.
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.dithered_q.size() != 0) @(posedge clock);
   endtask

   // Writes both size registers back to back; valid stays high between them.
   task automatic configure(input logic [CSR_DATA_W-1:0] wdata,
                            input logic [CSR_DATA_W-1:0] hdata);
      csr_valid <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_data  <= wdata;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_data  <= hdata;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sets a new image size once idle, then streams pixels of one style.
   task automatic run_phase(input logic [CSR_DATA_W-1:0] wdata,
                            input logic [CSR_DATA_W-1:0] hdata,
                            input int count, input int style);
      int unsigned      base;
      logic [PIX_W-1:0] r;
      logic [PIX_W-1:0] g;
      logic [PIX_W-1:0] b;
      wait_drain();
      configure(wdata, hdata);
      settings++;
      base = $urandom_range(255);
      for (int i = 0; i < count; i++) begin
         case (style)
            STYLE_FLAT: begin
               r = (base > 252) ? PIX_W'(base) : PIX_W'(base + $urandom_range(3));
               g = (base > 252) ? PIX_W'(base) : PIX_W'(base + $urandom_range(3));
               b = (base > 252) ? PIX_W'(base) : PIX_W'(base + $urandom_range(3));
            end
            STYLE_SATURATED: begin
               r = $urandom_range(1) ? 8'hFF : 8'h00;
               g = $urandom_range(1) ? 8'hFF : 8'h00;
               b = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            STYLE_RAMP: begin
               r = PIX_W'(base + i * 5);
               g = r;
               b = r;
            end
            default: begin
               r = PIX_W'($urandom_range(255));
               g = PIX_W'($urandom_range(255));
               b = PIX_W'($urandom_range(255));
            end
         endcase
         send_pixel(r, g, b);
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] hdata;
      int unsigned           ew;
      int unsigned           eh;
      int unsigned           frame_px;
      int                    count;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: extremes at the reset size, then a small full frame.
      for (int i = 0; i < 24; i++) begin
         if (i == 12) begin
            wait_drain();
            configure(13'd3, 13'd3);
            settings++;
         end
         send_pixel(DIRECTED_RGB[i][23:16], DIRECTED_RGB[i][15:8], DIRECTED_RGB[i][7:0]);
      end

      // Size extremes: masked and saturated width, zero and saturated height.
      run_phase(13'h1FFF, 13'd1, 1030, STYLE_NOISE);
      run_phase(13'd0, 13'h1FFF, 40, STYLE_FLAT);
      run_phase(13'd0, 13'd0, 20, STYLE_NOISE);
      run_phase(13'd1024, 13'd4096, 60, STYLE_RAMP);
      run_phase(13'd1, 13'd3, 12, STYLE_SATURATED);

      // Random image sizes, mostly small, with whole and partial frames.
      while (sent < TOTAL_PIXELS) begin
         case ($urandom_range(7))
            0:       wdata = '0;
            1:       wdata = 13'd1;
            2:       wdata = 13'h1800 | CSR_DATA_W'($urandom_range(2, 6));
            default: wdata = CSR_DATA_W'($urandom_range(2, 12));
         endcase
         case ($urandom_range(7))
            0:       hdata = '0;
            1:       hdata = 13'd1;
            2:       hdata = 13'h1FFF;
            default: hdata = CSR_DATA_W'($urandom_range(2, 6));
         endcase
         ew = wdata[WIDTH_REG_W-1:0];
         ew = (ew == 0) ? 1 : ((ew > MAX_WIDTH) ? MAX_WIDTH : ew);
         eh = hdata[HEIGHT_REG_W-1:0];
         eh = (eh == 0) ? 1 : ((eh > MAX_HEIGHT) ? MAX_HEIGHT : eh);
         frame_px = ew * eh;
         if (frame_px <= 100) begin
            count = frame_px * $urandom_range(1, 3);
            if ($urandom_range(2) == 0) count += $urandom_range(frame_px - 1);
         end else begin
            count = $urandom_range(20, 120);
         end
         run_phase(wdata, hdata, count, $urandom_range(3));
      end

      wait_drain();
      repeat (8) @(posedge clock);

      $display("Checked %0d pixel beats over %0d image sizes, with idle gaps on each side.",
               sb.checked, settings);
      $display("Saw %0d frame ends and %0d white pixels.", sb.frames, sb.whites);
      if (sb.mismatches == 0 && sb.dithered_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/gedd_pkg.sv
rtl/gedd_front.sv
rtl/gedd_queue.sv
rtl/gedd_back.sv
rtl/gray_error_diffusion_dither.sv
test/gray_error_diffusion_dither_tb.sv
